// ----- design/mqf_pkg.sv -----
// ----------------------------------------------------------------------------
// mqf_pkg
// Shared widths, codes and defaults of the multi-queue message FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

package mqf_pkg;

  localparam int QUEUES_DEF = 16;
  localparam int DEPTH_DEF  = 8;

  localparam int KIND_W   = 2;
  localparam int QID_W    = 8;
  localparam int BODY_W   = 64;
  localparam int SENDER_W = 8;
  localparam int STATUS_W = 3;
  localparam int MSG_W    = BODY_W + SENDER_W;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // register index, taken from paddr[2]
  localparam logic REG_IPC_ENABLE = 1'b0;

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR = 2'd0,
    KIND_SEND  = 2'd1,
    KIND_RECV  = 2'd2,
    KIND_NOP   = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 3'd0,
    ST_OFF   = 3'd1,
    ST_BADQ  = 3'd2,
    ST_FULL  = 3'd3,
    ST_EMPTY = 3'd4,
    ST_NOCUR = 3'd5
  } status_e;

  typedef struct packed {
    kind_e               kind;
    logic [QID_W-1:0]    queue_id;
    logic                has_current;
    logic [BODY_W-1:0]   msg_body;
    logic [SENDER_W-1:0] msg_sender;
  } item_t;

  typedef struct packed {
    logic wr;
    logic rd;
  } store_ctl_t;

endpackage

`default_nettype wire

// ----- design/mqf_if.sv -----
// ----------------------------------------------------------------------------
// mqf_if
// Request and response channels of the multi-queue message FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

interface mqf_req_if import mqf_pkg::*;;
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [QID_W-1:0]    queue_id;
  logic                has_current;
  logic [BODY_W-1:0]   msg_body;
  logic [SENDER_W-1:0] msg_sender;

  modport source (output valid, kind, queue_id, has_current, msg_body, msg_sender,
                  input ready);
  modport sink   (input valid, kind, queue_id, has_current, msg_body, msg_sender,
                  output ready);
endinterface

interface mqf_rsp_if import mqf_pkg::*;;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [BODY_W-1:0]   out_body;
  logic [SENDER_W-1:0] out_sender;

  modport source (output valid, status, out_body, out_sender, input ready);
  modport sink   (input valid, status, out_body, out_sender, output ready);
endinterface

`default_nettype wire

// ----- design/mqf_store.sv -----
// ----------------------------------------------------------------------------
// mqf_store
// Shared message store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mqf_store import mqf_pkg::*; #(
  parameter int ENTRIES = QUEUES_DEF * DEPTH_DEF,
  parameter int DW      = MSG_W
) (
  input  logic                       clk_i,
  input  store_ctl_t                 ctl_i,
  input  logic [$clog2(ENTRIES)-1:0] waddr_i,
  input  logic [$clog2(ENTRIES)-1:0] raddr_i,
  input  logic [DW-1:0]              wdata_i,
  output logic [DW-1:0]              rdata_o
);

  logic [DW-1:0] mem_q [ENTRIES];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (ctl_i.rd) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- design/multi_queue_message_fifo_top.sv -----
// ----------------------------------------------------------------------------
// multi_queue_message_fifo_top
// Bank of circular message queues with per-queue pointers and a shared store.
//
//   channel  dir  handshake        payload
//   req_i    in   valid / ready    kind, queue_id, has_current, msg_body, msg_sender
//   rsp_o    out  valid / ready    status, out_body, out_sender
//   apb      in   psel / penable   paddr, pwdata -> prdata (ipc_enable at 0x0)
//
// One item at a time: the queue-state memory read is registered on accept, the
// item is evaluated in S_EVAL, and a successful receive adds S_READ for the store read.
// Reset clears the enable and marks every queue entry invalid (reads as
// empty), with no sweep. A stalled response holds the last step of the item.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_queue_message_fifo_top import mqf_pkg::*; #(
  parameter int QUEUES = QUEUES_DEF,
  parameter int DEPTH  = DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  mqf_req_if.sink           req_i,
  mqf_rsp_if.source         rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int QW    = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int SLOTS = QUEUES * DEPTH;
  localparam int AW    = $clog2(SLOTS);
  localparam int QSW   = 2 * PW + CW;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;

  logic [1:0]          state_q, state_d;
  item_t               item_q;
  logic [AW-1:0]       base_q;
  logic [QSW-1:0]      qrd_q;
  logic [QSW-1:0]      qmem_q [QUEUES];
  logic [QUEUES-1:0]   qvalid_q;
  logic                enable_q;

  logic                out_valid_q, out_valid_d;
  status_e             out_status_q;
  logic [BODY_W-1:0]   out_body_q;
  logic [SENDER_W-1:0] out_sender_q;

  logic                accept, out_free, load_out;
  status_e             load_status;
  logic                load_msg;
  logic [QW-1:0]       qi, req_qi;
  logic                bad_q, qvalid;
  logic [PW-1:0]       cur_head, cur_tail, nxt_head, nxt_tail;
  logic [CW-1:0]       cur_count;
  logic                do_clear, do_send, do_recv;
  status_e             status;
  logic                qwe;
  logic [QSW-1:0]      qnext;
  store_ctl_t          sctl;
  logic [AW-1:0]       waddr, raddr;
  logic [MSG_W-1:0]    rdata;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
    end else if (psel && penable && pwrite && paddr[2] == REG_IPC_ENABLE) begin
      enable_q <= pwdata[0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_IPC_ENABLE) ? {{(APB_DW-1){1'b0}}, enable_q} : '0;

  // request side
  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign req_qi      = req_i.queue_id[QW-1:0];
  assign out_free    = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_t'{kind:        kind_e'(req_i.kind),
                        queue_id:    req_i.queue_id,
                        has_current: req_i.has_current,
                        msg_body:    req_i.msg_body,
                        msg_sender:  req_i.msg_sender};
      base_q <= AW'(32'(req_qi) * 32'(DEPTH));
      qrd_q  <= qmem_q[req_qi];
    end
  end

  // evaluate
  assign qi        = item_q.queue_id[QW-1:0];
  assign bad_q     = {1'b0, item_q.queue_id} >= (QID_W + 1)'(QUEUES);
  assign qvalid    = qvalid_q[qi];
  assign cur_head  = qvalid ? qrd_q[QSW-1 -: PW]   : '0;
  assign cur_tail  = qvalid ? qrd_q[CW+PW-1 -: PW] : '0;
  assign cur_count = qvalid ? qrd_q[CW-1:0]        : '0;
  assign nxt_head  = (cur_head == PW'(DEPTH - 1)) ? '0 : cur_head + 1'b1;
  assign nxt_tail  = (cur_tail == PW'(DEPTH - 1)) ? '0 : cur_tail + 1'b1;

  always_comb begin
    status   = ST_OK;
    do_clear = 1'b0;
    do_send  = 1'b0;
    do_recv  = 1'b0;
    case (item_q.kind)
      KIND_CLEAR: begin
        if (bad_q) status = ST_BADQ;
        else       do_clear = 1'b1;
      end
      KIND_SEND: begin
        if (!enable_q)                     status = ST_OFF;
        else if (bad_q)                    status = ST_BADQ;
        else if (cur_count == CW'(DEPTH))  status = ST_FULL;
        else                               do_send = 1'b1;
      end
      KIND_RECV: begin
        if (!enable_q)                 status = ST_OFF;
        else if (!item_q.has_current)  status = ST_NOCUR;
        else if (bad_q)                status = ST_BADQ;
        else if (cur_count == '0)      status = ST_EMPTY;
        else                           do_recv = 1'b1;
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  always_comb begin
    qnext = '0;
    if (do_send) begin
      qnext = {cur_head, nxt_tail, cur_count + 1'b1};
    end else if (do_recv) begin
      qnext = {nxt_head, cur_tail, cur_count - 1'b1};
    end
  end

  assign qwe     = (state_q == S_EVAL) && (do_recv || (out_free && (do_clear || do_send)));
  assign sctl.wr = (state_q == S_EVAL) && out_free && do_send;
  assign sctl.rd = (state_q == S_EVAL) && do_recv;
  assign waddr   = base_q + AW'(cur_tail);
  assign raddr   = base_q + AW'(cur_head);

  always_ff @(posedge clk_i) begin
    if (qwe) begin
      qmem_q[qi] <= qnext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qvalid_q <= '0;
    end else if (qwe) begin
      qvalid_q[qi] <= 1'b1;
    end
  end

  mqf_store #(
    .ENTRIES (SLOTS),
    .DW      (MSG_W)
  ) u_mqf_store (
    .clk_i   (clk_i),
    .ctl_i   (sctl),
    .waddr_i (waddr),
    .raddr_i (raddr),
    .wdata_i ({item_q.msg_sender, item_q.msg_body}),
    .rdata_o (rdata)
  );

  // sequencer
  always_comb begin
    state_d     = state_q;
    load_out    = 1'b0;
    load_msg    = 1'b0;
    load_status = status;
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_EVAL;
      end
      S_EVAL: begin
        if (do_recv) begin
          state_d = S_READ;
        end else if (out_free) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_READ: begin
        load_status = ST_OK;
        if (out_free) begin
          load_out = 1'b1;
          load_msg = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = load_out ? 1'b1 : (rsp_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_status_q <= load_status;
      out_body_q   <= load_msg ? rdata[BODY_W-1:0] : '0;
      out_sender_q <= load_msg ? rdata[MSG_W-1 -: SENDER_W] : '0;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.status     = out_status_q;
  assign rsp_o.out_body   = out_body_q;
  assign rsp_o.out_sender = out_sender_q;

endmodule

`default_nettype wire

// ----- design/mqf_checker.sv -----
// ----------------------------------------------------------------------------
// mqf_checker
// Port-level checks of the multi-queue message FIFO, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mqf_checker import mqf_pkg::*; (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_i,
  input wire logic                out_valid_i,
  input wire logic                out_ready_i,
  input wire logic [STATUS_W-1:0] status_i,
  input wire logic [BODY_W-1:0]   out_body_i,
  input wire logic [SENDER_W-1:0] out_sender_i,
  input wire logic                pready_i
);

  // hold a stalled response
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i)
      && $stable(out_body_i) && $stable(out_sender_i))
    else $error("response changed while stalled");

  // drop the message on every refusal
  a_zero_on_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != ST_OK |-> out_body_i == '0 && out_sender_i == '0)
    else $error("message returned with a failing status");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> status_i <= ST_NOCUR)
    else $error("status code out of range");

  // one item in flight: no transfer right after a transfer
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request taken while an item is in flight");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready_i)
    else $error("pready low");

endmodule

bind multi_queue_message_fifo_top mqf_checker u_mqf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (req_i.valid),
  .in_ready_i   (req_i.ready),
  .out_valid_i  (rsp_o.valid),
  .out_ready_i  (rsp_o.ready),
  .status_i     (rsp_o.status),
  .out_body_i   (rsp_o.out_body),
  .out_sender_i (rsp_o.out_sender),
  .pready_i     (pready)
);

`default_nettype wire
